FILE: src/rba_pkg.sv
// Shared widths, data types and the arctangent constants for the relative bearing unit.
package rba_pkg;

  // Configuration of the datapath.
  localparam int CORDIC_STAGES = 16;
  localparam int COORD_WIDTH   = 32;
  localparam int MAX_STAGES    = 24;

  // Port width of every coordinate field and of the result field.
  localparam int IN_W  = 32;
  localparam int OUT_W = 16;

  // Coordinate bits that are actually used, and the exact width of a difference.
  localparam int EFF_W = (COORD_WIDTH > IN_W) ? IN_W : COORD_WIDTH;
  localparam int DW    = EFF_W + 1;

  // Magnitude width before normalization; at least one bit above the window.
  localparam int MAG_W = (DW > 31) ? DW : 31;

  // Normalized magnitudes lie in [2^29, 2^30).
  localparam int NM_W = 30;

  // Right shift count when the magnitude is above the window.
  localparam int KW = $clog2(MAG_W - 28);

  // Leading-zero normalization cells shift by 16, 8, 4, 2 and 1.
  localparam int NORM_CELLS = 5;
  localparam int SH_W       = NORM_CELLS;

  // Rotation datapath width: gain times sqrt(2) times 2^30 stays below 2^32.
  localparam int CW    = 34;
  localparam int ANG_W = 32;

  localparam int CORDIC_N  = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int STG_IDX_W = $clog2(MAX_STAGES);

  // Registers through one bearing unit: fold, coarse shift, normalize, sign, rotate.
  localparam int BRG_LAT = 3 + NORM_CELLS + CORDIC_N;

  localparam logic [ANG_W-1:0] QUARTER_TURN = ANG_W'(1) << (ANG_W - 2);
  localparam logic [ANG_W-1:0] ROUND_HALF   = ANG_W'(1) << (ANG_W - OUT_W - 1);

  // Vector in magnitude form while it is being normalized.
  typedef struct packed {
    logic [NM_W-1:0]  mx;
    logic [NM_W-1:0]  my;
    logic             sy;
    logic [ANG_W-1:0] z;
  } nvec_t;

  // Vector in signed form inside the rotation chain.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ANG_W-1:0]     z;
  } cvec_t;

  // atan(2^-i) in binary angle units, 2^32 per full turn, rounded to nearest.
  function automatic logic [ANG_W-1:0] atan_lut(input logic [STG_IDX_W-1:0] idx);
    logic [ANG_W-1:0] a;
    case (idx)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2FA;
      5'd15:   a = 32'h0000_517D;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A30;
      5'd19:   a = 32'h0000_0518;
      5'd20:   a = 32'h0000_028C;
      5'd21:   a = 32'h0000_0146;
      5'd22:   a = 32'h0000_00A3;
      5'd23:   a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: src/rba_norm_cell.sv
// One normalization cell: shifts both magnitudes left when the result stays in range.
module rba_norm_cell
  import rba_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [SH_W-1:0] sh,
  input  nvec_t           d_i,
  output nvec_t           d_o
);

  logic [SH_W:0]   lim;
  logic [NM_W-1:0] m_or;
  logic            fits;
  nvec_t           d_nxt;
  nvec_t           d_r;

  // The OR of both magnitudes has the same bit length as their maximum.
  always_comb begin
    m_or  = d_i.mx | d_i.my;
    lim   = (SH_W + 1)'(NM_W) - {1'b0, sh};
    fits  = ((m_or >> lim) == '0);
    d_nxt = d_i;
    if (fits) begin
      d_nxt.mx = d_i.mx << sh;
      d_nxt.my = d_i.my << sh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

FILE: src/rba_cordic_cell.sv
// One vectoring rotation cell: turns the vector toward the positive north axis.
module rba_cordic_cell
  import rba_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [STG_IDX_W-1:0] stg,
  input  cvec_t                d_i,
  output cvec_t                d_o
);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic [ANG_W-1:0]     a;
  cvec_t                d_nxt;
  cvec_t                d_r;

  always_comb begin
    xs = d_i.x >>> stg;
    ys = d_i.y >>> stg;
    a  = atan_lut(stg);
    // A non-negative east part turns clockwise.
    if (!d_i.y[CW-1]) begin
      d_nxt.x = d_i.x + ys;
      d_nxt.y = d_i.y - xs;
      d_nxt.z = d_i.z + a;
    end else begin
      d_nxt.x = d_i.x - ys;
      d_nxt.y = d_i.y + xs;
      d_nxt.z = d_i.z - a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

FILE: src/rba_bearing.sv
// Compass bearing of one vector: half-plane fold, normalization and a chain of rotation cells.
module rba_bearing
  import rba_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] north,
  input  logic signed [DW-1:0] east,
  output logic [ANG_W-1:0]     angle
);

  typedef struct packed {
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    logic             sy;
    logic [ANG_W-1:0] z;
  } wvec_t;

  logic signed [MAG_W:0] n_ext;
  logic signed [MAG_W:0] e_ext;
  logic signed [MAG_W:0] n_abs;
  logic signed [MAG_W:0] e_abs;
  wvec_t                 w_nxt;
  wvec_t                 w_r;

  logic [MAG_W-1:0]      m_or;
  logic [KW-1:0]         k;
  nvec_t                 n0_nxt;
  nvec_t                 n0_r;

  logic signed [CW-1:0]  my_ext;
  cvec_t                 c0_nxt;
  cvec_t                 c0_r;

  nvec_t                 n_arr [NORM_CELLS+1];
  cvec_t                 c_arr [CORDIC_N+1];

  // Fold a vector with negative north part into the right half plane by a quarter turn.
  always_comb begin
    n_ext    = (MAG_W + 1)'(north);
    e_ext    = (MAG_W + 1)'(east);
    n_abs    = n_ext[MAG_W] ? -n_ext : n_ext;
    e_abs    = e_ext[MAG_W] ? -e_ext : e_ext;
    w_nxt.sy = east[DW-1];
    if (north[DW-1]) begin
      w_nxt.mx = e_abs[MAG_W-1:0];
      w_nxt.my = n_abs[MAG_W-1:0];
      w_nxt.z  = east[DW-1] ? ('0 - QUARTER_TURN) : QUARTER_TURN;
    end else begin
      w_nxt.mx = n_abs[MAG_W-1:0];
      w_nxt.my = e_abs[MAG_W-1:0];
      w_nxt.z  = '0;
    end
  end

  // Coarse right shift for magnitudes at or above 2^30; truncation toward zero.
  always_comb begin
    m_or = w_r.mx | w_r.my;
    k    = '0;
    for (int j = 30; j < MAG_W; j++) begin
      if (m_or[j]) begin
        k = KW'(j - 29);
      end
    end
    n0_nxt.mx = NM_W'(w_r.mx >> k);
    n0_nxt.my = NM_W'(w_r.my >> k);
    n0_nxt.sy = w_r.sy;
    n0_nxt.z  = w_r.z;
  end

  // Back to signed form for the rotation chain.
  always_comb begin
    my_ext   = CW'(n_arr[NORM_CELLS].my);
    c0_nxt.x = CW'(n_arr[NORM_CELLS].mx);
    c0_nxt.y = n_arr[NORM_CELLS].sy ? -my_ext : my_ext;
    c0_nxt.z = n_arr[NORM_CELLS].z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r  <= w_nxt;
      n0_r <= n0_nxt;
      c0_r <= c0_nxt;
    end
  end

  assign n_arr[0] = n0_r;
  assign c_arr[0] = c0_r;

  genvar g;
  for (g = 0; g < NORM_CELLS; g++) begin : g_norm
    rba_norm_cell u_cell (
      .clk (clk),
      .en  (en),
      .sh  (SH_W'(1) << (NORM_CELLS - 1 - g)),
      .d_i (n_arr[g]),
      .d_o (n_arr[g+1])
    );
  end

  for (g = 0; g < CORDIC_N; g++) begin : g_rot
    rba_cordic_cell u_cell (
      .clk (clk),
      .en  (en),
      .stg (STG_IDX_W'(g)),
      .d_i (c_arr[g]),
      .d_o (c_arr[g+1])
    );
  end

  assign angle = c_arr[CORDIC_N].z;

endmodule

FILE: src/relative_bearing_atan2_unit.sv
// Top level of the relative bearing unit: target bearing minus view bearing.
// Path: a request is registered at stage 0, then passes through both bearing pipelines
// and the output register, where its result shows at out_valid.
// Throughput: one request per cycle; the pipeline only halts while a finished
// result waits at the output under out_stall.
// Reset: synchronous, active low; clears every valid bit, payload is not reset.
module relative_bearing_atan2_unit
  import rba_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  in_listener_x,
  input  logic signed [IN_W-1:0]  in_listener_y,
  input  logic signed [IN_W-1:0]  in_view_x,
  input  logic signed [IN_W-1:0]  in_view_y,
  input  logic signed [IN_W-1:0]  in_target_x,
  input  logic signed [IN_W-1:0]  in_target_y,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_relative_angle
);

  // Every stage moves together. The pipeline advances unless the output
  // register holds a result that the receiver is stalling; a bubble in the
  // output register therefore never blocks a new request.
  logic                    pipe_en;

  // Stage 0: sign-extended coordinates and exact differences.
  logic signed [DW-1:0]    lx_e;
  logic signed [DW-1:0]    ly_e;
  logic signed [DW-1:0]    tx_e;
  logic signed [DW-1:0]    ty_e;
  logic signed [DW-1:0]    dx_nxt;
  logic signed [DW-1:0]    dy_nxt;
  logic signed [DW-1:0]    vx_nxt;
  logic signed [DW-1:0]    vy_nxt;
  logic signed [DW-1:0]    dx_r;
  logic signed [DW-1:0]    dy_r;
  logic signed [DW-1:0]    vx_r;
  logic signed [DW-1:0]    vy_r;
  logic                    zd_nxt;
  logic                    zv_nxt;

  // Valid bit of stage 0 and of every bearing stage.
  logic [BRG_LAT:0]        vld_r;

  // Special-case flags travel beside the bearing pipelines, one entry per
  // valid bit, so the last entry lines up with the finished bearings.
  logic                    zd_line_r [BRG_LAT+1];
  logic                    zv_line_r [BRG_LAT+1];

  logic [ANG_W-1:0]        bt;
  logic [ANG_W-1:0]        bv;
  logic [ANG_W-1:0]        bv_eff;
  logic [ANG_W-1:0]        diff;
  logic [ANG_W-1:0]        rnd;
  logic signed [OUT_W-1:0] ang_nxt;

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_relative_angle_r;

  assign pipe_en  = !(out_valid_r && out_stall);
  assign in_stall = !pipe_en;

  // Only the low EFF_W bits of each coordinate count. The differences carry
  // one more bit than the coordinates so they are always exact.
  always_comb begin
    lx_e   = DW'(signed'(in_listener_x[EFF_W-1:0]));
    ly_e   = DW'(signed'(in_listener_y[EFF_W-1:0]));
    tx_e   = DW'(signed'(in_target_x[EFF_W-1:0]));
    ty_e   = DW'(signed'(in_target_y[EFF_W-1:0]));
    vx_nxt = DW'(signed'(in_view_x[EFF_W-1:0]));
    vy_nxt = DW'(signed'(in_view_y[EFF_W-1:0]));
    dx_nxt = tx_e - lx_e;
    dy_nxt = ty_e - ly_e;
    zd_nxt = (dx_nxt == '0) && (dy_nxt == '0);
    zv_nxt = (vx_nxt == '0) && (vy_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dx_r         <= dx_nxt;
      dy_r         <= dy_nxt;
      vx_r         <= vx_nxt;
      vy_r         <= vy_nxt;
      zd_line_r[0] <= zd_nxt;
      zv_line_r[0] <= zv_nxt;
      for (int i = 1; i <= BRG_LAT; i++) begin
        zd_line_r[i] <= zd_line_r[i-1];
        zv_line_r[i] <= zv_line_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[BRG_LAT-1:0], in_valid};
    end
  end

  // Two identical bearing pipelines: the target offset and the view vector.
  // Bearings are atan2(east, north), clockwise positive.
  rba_bearing u_brg_tgt (
    .clk   (clk),
    .en    (pipe_en),
    .north (dy_r),
    .east  (dx_r),
    .angle (bt)
  );

  rba_bearing u_brg_view (
    .clk   (clk),
    .en    (pipe_en),
    .north (vy_r),
    .east  (vx_r),
    .angle (bv)
  );

  // The binary-angle difference wraps by itself into [-pi, pi); it is then
  // rounded to 16 bits, so a difference of +pi comes out as -pi. A zero
  // view vector stands for north, and a target on the listener gives zero.
  always_comb begin
    bv_eff = zv_line_r[BRG_LAT] ? '0 : bv;
    diff   = bt - bv_eff;
    rnd    = diff + ROUND_HALF;
    if (zd_line_r[BRG_LAT]) begin
      ang_nxt = '0;
    end else begin
      ang_nxt = rnd[ANG_W-1 -: OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= vld_r[BRG_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_relative_angle_r <= ang_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_relative_angle = out_relative_angle_r;

`ifndef SYNTHESIS
  // A stalled output freezes every stage of the pipeline.
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_stall |=> $stable(vld_r))
    else $error("pipeline moved while the output was stalled");

  // An accepted request always enters stage 0.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall |=> vld_r[0])
    else $error("accepted request was not captured");

  // No result appears without a request in the last bearing stage.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && pipe_en && !vld_r[BRG_LAT] |=> !out_valid)
    else $error("result appeared without a request behind it");

  // A target on the listener gives a zero relative angle.
  a_coincident_zero: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && pipe_en && vld_r[BRG_LAT] && zd_line_r[BRG_LAT]
    |=> out_relative_angle == '0)
    else $error("coincident target did not give zero");
`endif

endmodule

FILE: dv/relative_bearing_atan2_unit_test.sv
// Self-checking testbench for the relative bearing unit, with directed and random requests.
module relative_bearing_atan2_unit_test;
  import rba_pkg::*;

  // Clock, reset and run limits.
  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_N     = 1680;
  // Cycles without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT  = 1000;
  // After the last result, wait longer than the pipeline is deep.
  localparam int DRAIN_CYCLES = 2 * (CORDIC_N + 9);
  // Requests and results in this window see no idling on either side.
  localparam int STEADY_FROM  = 700;
  localparam int STEADY_TO    = 1000;
  // After this many results the receiver holds off long enough to fill the pipeline.
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 150;
  localparam int IDLE_PERCENT = 34;

  // Handy coordinates: one metre in Q23.8 and the extremes of a field.
  localparam logic signed [IN_W-1:0] METRE = 256;
  localparam logic signed [IN_W-1:0] CMAX  = 32'sh7FFF_FFFF;
  localparam logic signed [IN_W-1:0] CMIN  = 32'sh8000_0000;

  // A directed row either carries its expected angle or leaves it to the predictor.
  localparam bit ANGLE_KNOWN     = 1'b1;
  localparam bit ANGLE_PREDICTED = 1'b0;

  // Magnitude window that the vectoring step normalizes into.
  localparam longint WINDOW_HI = 1 << 30;
  localparam longint WINDOW_LO = 1 << 29;

  // atan(2^-i) in 32-bit binary angle units, rounded to nearest.
  localparam logic [0:23][31:0] ARCTAN = {
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  // One request: listener, view and target, plus an optional hand-written answer.
  typedef struct packed {
    logic signed [IN_W-1:0]  lx;
    logic signed [IN_W-1:0]  ly;
    logic signed [IN_W-1:0]  vx;
    logic signed [IN_W-1:0]  vy;
    logic signed [IN_W-1:0]  tx;
    logic signed [IN_W-1:0]  ty;
    bit                      known;
    logic signed [OUT_W-1:0] angle;
  } bearing_req_t;

  // Shapes of random requests, each aimed at a different corner of the datapath.
  typedef enum int {
    SHAPE_FULL,
    SHAPE_SMALL,
    SHAPE_ON_LISTENER,
    SHAPE_NO_VIEW,
    SHAPE_OPPOSITE,
    SHAPE_AXIS,
    SHAPE_CLOSE,
    SHAPE_EXTREME
  } shape_t;

  localparam int DIRECTED_N = 22;

  // Directed requests. Only the rows whose target sits on the listener have an
  // answer that is obvious by hand (zero); the rest go through the predictor.
  bearing_req_t directed_rows [DIRECTED_N] = '{
    // Everything at the origin, view vector zero as well.
    '{0, 0, 0, 0, 0, 0, ANGLE_KNOWN, 0},
    // Target on listener at the corners of the range with extreme views, and at (-1, -1).
    '{CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, ANGLE_KNOWN, 0},
    '{CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, ANGLE_KNOWN, 0},
    '{-1, -1, 123, -456, -1, -1, ANGLE_KNOWN, 0},
    // The four compass points with a zero view, which counts as north.
    '{0, 0, 0, 0, 0, METRE, ANGLE_PREDICTED, 0},
    '{0, 0, 0, 0, METRE, 0, ANGLE_PREDICTED, 0},
    '{0, 0, 0, 0, 0, -METRE, ANGLE_PREDICTED, 0},
    '{0, 0, 0, 0, -METRE, 0, ANGLE_PREDICTED, 0},
    // Target exactly behind the view, from three directions; +pi must wrap to -pi.
    '{0, 0, 0, METRE, 0, -METRE, ANGLE_PREDICTED, 0},
    '{0, 0, 0, -METRE, 0, METRE, ANGLE_PREDICTED, 0},
    '{0, 0, METRE, 0, -METRE, 0, ANGLE_PREDICTED, 0},
    // Southern half plane, both east signs, so the quarter-turn fold is used.
    '{0, 0, METRE, METRE, -METRE, -METRE, ANGLE_PREDICTED, 0},
    '{0, 0, -METRE, METRE, METRE, -METRE, ANGLE_PREDICTED, 0},
    // Full-width deltas that need the extra bit and the most halving.
    '{CMIN, CMIN, 1, 0, CMAX, CMAX, ANGLE_PREDICTED, 0},
    '{CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, ANGLE_PREDICTED, 0},
    '{CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, ANGLE_PREDICTED, 0},
    '{0, CMAX, 0, CMAX, 0, CMIN, ANGLE_PREDICTED, 0},
    // Vectors of one to seven LSBs that need much doubling.
    '{0, 0, 0, -1, 1, 0, ANGLE_PREDICTED, 0},
    '{0, 0, -1, 0, 0, -1, ANGLE_PREDICTED, 0},
    '{0, 0, -1, -1, 3, -7, ANGLE_PREDICTED, 0},
    // Alternating bit patterns in every field.
    '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
      32'h5555_5555, ANGLE_PREDICTED, 0},
    // View just east of south, target just west of south: the difference sits
    // next to the wrap between -pi and +pi.
    '{3 * METRE, -5 * METRE, 1, -METRE, 3 * METRE - 1, -6 * METRE, ANGLE_PREDICTED, 0}
  };

  // Every input starts at a known value so the block never sees X.
  logic                    clk                = 1'b0;
  logic                    rst_n              = 1'b0;
  logic                    in_valid           = 1'b0;
  logic                    in_stall;
  logic signed [IN_W-1:0]  in_listener_x      = '0;
  logic signed [IN_W-1:0]  in_listener_y      = '0;
  logic signed [IN_W-1:0]  in_view_x          = '0;
  logic signed [IN_W-1:0]  in_view_y          = '0;
  logic signed [IN_W-1:0]  in_target_x        = '0;
  logic signed [IN_W-1:0]  in_target_y        = '0;
  logic                    out_valid;
  logic                    out_stall          = 1'b0;
  logic signed [OUT_W-1:0] out_relative_angle;

  // The hand-written answer travels beside the request payload, so the
  // monitor samples it at the same edge as the request itself.
  bit                      req_known          = 1'b0;
  logic signed [OUT_W-1:0] req_angle          = '0;

  // Angles still owed by the block, oldest first.
  logic signed [OUT_W-1:0] owed_angles [$];
  logic signed [OUT_W-1:0] owed_angle;

  // Handshake counters change only with nonblocking updates, so every process
  // that looks at them on a clock edge sees the same value.
  int requests_taken = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  bit hold_done      = 1'b0;

  relative_bearing_atan2_unit i_dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  // A field as the block reads it: its low EFF_W bits, sign extended.
  function automatic longint coord_value(input logic [IN_W-1:0] raw);
    longint v;
    v = $signed(raw);
    v = (v <<< (64 - EFF_W)) >>> (64 - EFF_W);
    return v;
  endfunction

  function automatic longint larger_mag(input longint a, input longint b);
    longint ma, mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    return (ma > mb) ? ma : mb;
  endfunction

  // Compass bearing atan2(east, north) as a 32-bit binary angle, by vectoring
  // rotations. The caller never passes the zero vector.
  function automatic logic [31:0] compass_bearing(input longint north, input longint east);
    longint x, y, z, t, m, xs, ys;
    x = north;
    y = east;
    z = 0;
    // Fold the southern half plane up by a quarter turn.
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = WINDOW_HI;
      end else begin
        x = -y;
        y = t;
        z = -WINDOW_HI;
      end
    end
    // Bring the larger magnitude into [2^29, 2^30); halving rounds toward zero.
    m = larger_mag(x, y);
    while (m >= WINDOW_HI) begin
      x = x / 2;
      y = y / 2;
      m = larger_mag(x, y);
    end
    while (m < WINDOW_LO) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    // Drive the east part to zero; a non-negative east part turns clockwise.
    for (int i = 0; i < CORDIC_N; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ARCTAN[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ARCTAN[i]);
      end
    end
    return z[31:0];
  endfunction

  // Bearing of the target from the listener, minus the view bearing, rounded
  // to a 16-bit binary angle. A target on the listener always gives zero.
  function automatic logic signed [OUT_W-1:0] predict_relative_angle(
    input logic [IN_W-1:0] lx, input logic [IN_W-1:0] ly,
    input logic [IN_W-1:0] vx, input logic [IN_W-1:0] vy,
    input logic [IN_W-1:0] tx, input logic [IN_W-1:0] ty);
    longint      dx, dy, ex, ey;
    logic [31:0] to_target, to_view, rounded;
    dx = coord_value(tx) - coord_value(lx);
    dy = coord_value(ty) - coord_value(ly);
    if (dx == 0 && dy == 0)
      return '0;
    ex = coord_value(vx);
    ey = coord_value(vy);
    to_target = compass_bearing(dy, dx);
    to_view   = (ex != 0 || ey != 0) ? compass_bearing(ey, ex) : '0;
    // The 32-bit subtraction wraps the difference into [-pi, pi).
    rounded = to_target - to_view + (32'h1 << 15);
    return rounded[31:16];
  endfunction

  function automatic logic signed [IN_W-1:0] small_offset(input int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return v;
  endfunction

  function automatic logic signed [IN_W-1:0] extreme_coord();
    case ($urandom_range(0, 4))
      0:       return CMIN;
      1:       return CMAX;
      2:       return -1;
      3:       return 1;
      default: return 0;
    endcase
  endfunction

  // Random request: start from fully random fields, then reshape them.
  function automatic bearing_req_t random_request();
    bearing_req_t           r;
    logic signed [IN_W-1:0] ox, oy;
    shape_t                 shape;
    r.lx    = $urandom;
    r.ly    = $urandom;
    r.vx    = $urandom;
    r.vy    = $urandom;
    r.tx    = $urandom;
    r.ty    = $urandom;
    r.known = ANGLE_PREDICTED;
    r.angle = '0;
    ox      = small_offset(2048);
    oy      = small_offset(2048);
    shape   = shape_t'($urandom_range(0, SHAPE_EXTREME));
    case (shape)
      SHAPE_SMALL: begin
        r.lx = small_offset(1024);
        r.ly = small_offset(1024);
        r.vx = small_offset(1024);
        r.vy = small_offset(1024);
        r.tx = small_offset(1024);
        r.ty = small_offset(1024);
      end
      SHAPE_ON_LISTENER: begin
        r.tx = r.lx;
        r.ty = r.ly;
      end
      SHAPE_NO_VIEW: begin
        r.vx = '0;
        r.vy = '0;
        r.tx = r.lx + ox;
        r.ty = r.ly + oy;
      end
      // The view points straight away from the target, up to rounding.
      SHAPE_OPPOSITE: begin
        r.tx = r.lx + ox;
        r.ty = r.ly + oy;
        r.vx = -ox;
        r.vy = -oy;
      end
      // Delta and view along the axes, where the folding decisions flip.
      SHAPE_AXIS: begin
        if ($urandom_range(0, 1)) begin
          r.tx = r.lx;
          r.ty = r.ly + small_offset(65536);
          r.vx = '0;
        end else begin
          r.tx = r.lx + small_offset(65536);
          r.ty = r.ly;
          r.vy = '0;
        end
      end
      SHAPE_CLOSE: begin
        r.tx = r.lx + small_offset(256);
        r.ty = r.ly + small_offset(256);
      end
      SHAPE_EXTREME: begin
        r.lx = extreme_coord();
        r.ly = extreme_coord();
        r.vx = extreme_coord();
        r.vy = extreme_coord();
        r.tx = extreme_coord();
        r.ty = extreme_coord();
      end
      default: ;
    endcase
    return r;
  endfunction

  // Monitor: both handshakes are seen on the rising edge with the values that
  // held just before it. Each accepted request adds the angle it must produce;
  // each accepted result is compared with the oldest one still owed.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      owed_angles.push_back(req_known ? req_angle :
        predict_relative_angle(in_listener_x, in_listener_y, in_view_x, in_view_y,
                               in_target_x, in_target_y));
      requests_taken <= requests_taken + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (owed_angles.size() == 0) begin
        report_mismatch($sformatf("relative_angle %0d arrived with no request pending",
                                  out_relative_angle));
      end else begin
        owed_angle = owed_angles.pop_front();
        if (out_relative_angle !== owed_angle)
          report_mismatch($sformatf("result %0d: relative_angle %0d, expected %0d",
                                    results_seen, out_relative_angle, owed_angle));
      end
    end
  end

  // Receiver: stalls at random, keeps clear in the steady window, and once
  // holds off for a long stretch so the pipeline fills and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (results_seen >= STEADY_FROM && results_seen < STEADY_TO) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  // Watchdog: a run with no handshake on either side for too long is hung.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // Sender: reset, the directed table, then the random requests. Gaps are
  // random except in the steady window; a payload is held until accepted.
  initial begin : sender
    bearing_req_t req;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    for (int idx = 0; idx < DIRECTED_N + RANDOM_N; idx++) begin
      req = (idx < DIRECTED_N) ? directed_rows[idx] : random_request();
      if (idx < STEADY_FROM || idx >= STEADY_TO) begin
        while ($urandom_range(0, 99) < IDLE_PERCENT) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      end
      in_listener_x <= req.lx;
      in_listener_y <= req.ly;
      in_view_x     <= req.vx;
      in_view_y     <= req.vy;
      in_target_x   <= req.tx;
      in_target_y   <= req.ty;
      req_known     <= req.known;
      req_angle     <= req.angle;
      in_valid      <= 1'b1;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;

    // Wait for every owed result, then give the pipeline time to show any extra one.
    while (results_seen < requests_taken) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (owed_angles.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", owed_angles.size()));

    $display("run covered %0d directed and %0d random requests, %0d results compared",
             DIRECTED_N, RANDOM_N, results_seen);
    $display("shapes: coincident points, zero and opposite views, full-scale deltas, %0d-cycle hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
